[hdl/dsmfd_pkg.sv]
// ----------------------------------------------------------------------------
// dsmfd_pkg
// Shared types and constants for the DSM servo frame decoder.
// ----------------------------------------------------------------------------
package dsmfd_pkg;

	localparam int MAX_CHANNELS = 16;
	localparam int FRAME_BYTES  = 16;

	localparam int POS_W  = $clog2(FRAME_BYTES);
	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CHID_W = 6;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DATA_FORMAT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS   = 2'd2;

	localparam logic        FMT_DSMX         = 1'b0;
	localparam logic        FMT_DSM2         = 1'b1;
	localparam logic [4:0]  NUM_CH_RESET     = 5'd12;
	localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;
	localparam logic [15:0] TICKS_SATURATED  = 16'hFFFF;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] byte_value;
		logic       frame_start;
		logic [3:0] channel_index;
	} item_t;

	typedef struct packed {
		logic [10:0] read_value;
		logic        link_ok;
		logic        frame_done;
	} result_t;

	typedef struct packed {
		logic        data_format;
		logic [4:0]  num_channels;
		logic [15:0] timeout_ms;
	} cfg_t;

endpackage

[hdl/dsmfd_decode.sv]
// ----------------------------------------------------------------------------
// dsmfd_decode
// Frame state, channel store and link timer; one request per enabled cycle.
// ----------------------------------------------------------------------------
module dsmfd_decode import dsmfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	logic [POS_W-1:0] pos_q;
	logic             in_frame_q;
	logic [7:0]       high_byte_q;
	logic             stop_q;
	logic [10:0]      store_q [MAX_CHANNELS];
	logic [15:0]      ticks_q;

	logic             is_byte;
	logic             eff_in;
	logic [POS_W-1:0] eff_pos;
	logic             eff_stop;
	logic             last;
	logic             paired;
	logic [15:0]      word;
	logic [CHID_W-1:0] chan;
	logic [10:0]      val;
	logic             out_of_range;
	logic             do_write;
	logic             stop_next;
	logic [15:0]      ticks_next;
	logic [10:0]      rd_val;

	assign is_byte  = (item.opcode == OP_BYTE);
	assign eff_in   = item.frame_start | in_frame_q;
	assign eff_pos  = item.frame_start ? '0 : pos_q;
	assign eff_stop = item.frame_start ? 1'b0 : stop_q;
	assign last     = (eff_pos == POS_W'(FRAME_BYTES - 1));
	assign paired   = (eff_pos >= POS_W'(2)) && eff_pos[0];
	assign word     = {high_byte_q, item.byte_value};

	always_comb begin
		if (cfg.data_format == FMT_DSMX) begin
			chan = {1'b0, word[15:11]};
			val  = word[10:0];
		end else begin
			chan = word[15:10];
			val  = {word[9:0], 1'b0};
		end
	end

	assign out_of_range = (chan >= {1'b0, cfg.num_channels}) ||
		(chan >= CHID_W'(MAX_CHANNELS));
	assign do_write  = is_byte && eff_in && paired && !eff_stop && !out_of_range;
	assign stop_next = eff_stop | (paired && !eff_stop && out_of_range);

	always_comb begin
		ticks_next = ticks_q;
		if (is_byte && eff_in && last)
			ticks_next = '0;
		else if (item.opcode == OP_TICK && ticks_q != TICKS_SATURATED)
			ticks_next = ticks_q + 16'd1;
	end

	always_comb begin
		rd_val = '0;
		if (({2'b00, item.channel_index} < CHID_W'(MAX_CHANNELS)))
			rd_val = store_q[CH_W'(item.channel_index)];
	end

	assign res.read_value = (item.opcode == OP_READ) ? rd_val : '0;
	assign res.link_ok    = (ticks_next != TICKS_SATURATED) && (ticks_next <= cfg.timeout_ms);
	assign res.frame_done = is_byte && eff_in && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			in_frame_q  <= 1'b0;
			high_byte_q <= '0;
			stop_q      <= 1'b0;
			ticks_q     <= TICKS_SATURATED;
			for (int i = 0; i < MAX_CHANNELS; i++)
				store_q[i] <= '0;
		end else if (en) begin
			ticks_q <= ticks_next;
			if (is_byte && eff_in) begin
				in_frame_q <= 1'b1;
				if (eff_pos >= POS_W'(2) && !eff_pos[0])
					high_byte_q <= item.byte_value;
				if (do_write)
					store_q[chan[CH_W-1:0]] <= val;
				if (last) begin
					pos_q  <= '0;
					stop_q <= 1'b0;
				end else begin
					pos_q  <= eff_pos + POS_W'(1);
					stop_q <= stop_next;
				end
			end
		end
	end

	a_done_on_byte: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.frame_done |-> item.opcode == OP_BYTE)
		else $error("frame done without a byte");

	a_done_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.frame_done |=> pos_q == '0 && ticks_q == '0 && !stop_q)
		else $error("frame end did not restart position and timer");

	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		item.opcode != OP_READ |-> res.read_value == '0)
		else $error("read value on a non-read request");

	a_no_write_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |-> !eff_stop && eff_in)
		else $error("store written in a stopped frame");

endmodule

[hdl/dsm_servo_frame_decoder.sv]
// ----------------------------------------------------------------------------
// dsm_servo_frame_decoder
// DSMX / DSM2 satellite frame decoder with channel store and link timer.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  item    | item_valid, item_stall, item (item_t)    | in
//  result  | result_valid, result_stall, result       | out
//  config  | cfg_we, cfg_index, cfg_data              | in
//
//  Every request gives one result, held first in the input register and then
//  in the result register around the single decode step; one request per
//  cycle is sustained while result_stall is low.
//  Reset clears frame state and the 16-entry channel store, and marks the
//  link lost. item_stall rises only while a result waits and result_stall
//  is high.
// ----------------------------------------------------------------------------
module dsm_servo_frame_decoder import dsmfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_q;
	logic    result_valid_q;
	result_t dec_res;
	logic    adv;

	assign adv          = !result_valid_q || !result_stall;
	assign item_stall   = valid_s1 && !adv;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_format  <= FMT_DSMX;
			cfg_q.num_channels <= NUM_CH_RESET;
			cfg_q.timeout_ms   <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DATA_FORMAT:  cfg_q.data_format  <= cfg_data[0];
				CFG_NUM_CHANNELS: cfg_q.num_channels <= cfg_data[4:0];
				CFG_TIMEOUT_MS:   cfg_q.timeout_ms   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	dsmfd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1)
			result_q <= dec_res;
	end

endmodule

[verif/tb_dsm_servo_frame_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dsm_servo_frame_decoder
// Self-checking bench for the DSM servo frame decoder. A local decoder model
// predicts one result per accepted request (channel reads, link status and
// end of frame). Directed frames are followed by random frame traffic under
// several register settings, with random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_dsm_servo_frame_decoder;
	import dsmfd_pkg::*;

	localparam logic [1:0] OP_NONE     = 2'd3;
	localparam int         STALL_LIMIT = 4000;
	localparam int         IDLE_PCT    = 18;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	item_t                 req_bus      = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               rsp_bus;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	dsm_servo_frame_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (req_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (rsp_bus),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// decoder model state
	logic        fmt_q;
	logic [4:0]  chan_limit;
	logic [15:0] link_timeout;
	logic [3:0]  pos;
	logic        framing;
	logic [7:0]  hi_byte;
	logic        skip_rest;
	logic [10:0] servo [MAX_CHANNELS];
	logic [15:0] ms_count;

	result_t due_responses [$];
	int      fault_count = 0;
	int      idle_cycles = 0;
	int      sent_count  = 0;
	bit      steady      = 1'b0;
	bit      last_whole  = 1'b0;

	task automatic reset_predictor();
		fmt_q        = FMT_DSMX;
		chan_limit   = NUM_CH_RESET;
		link_timeout = TIMEOUT_RESET;
		pos          = '0;
		framing      = 1'b0;
		hi_byte      = '0;
		skip_rest    = 1'b0;
		ms_count     = TICKS_SATURATED;
		foreach (servo[i])
			servo[i] = '0;
	endtask

	task automatic decode_request(input item_t req, output result_t rsp);
		logic [15:0] word;
		logic [5:0]  chan;
		logic [10:0] val;
		rsp = '0;
		case (req.opcode)
			OP_BYTE: begin
				if (req.frame_start) begin
					framing   = 1'b1;
					pos       = '0;
					skip_rest = 1'b0;
				end
				if (framing) begin
					if (pos >= 2) begin
						if (!pos[0]) begin
							hi_byte = req.byte_value;
						end else if (!skip_rest) begin
							word = {hi_byte, req.byte_value};
							if (fmt_q) begin
								chan = word[15:10];
								val  = {word[9:0], 1'b0};
							end else begin
								chan = {1'b0, word[15:11]};
								val  = word[10:0];
							end
							if (chan >= chan_limit || chan >= MAX_CHANNELS)
								skip_rest = 1'b1;
							else
								servo[chan[3:0]] = val;
						end
					end
					if (pos == FRAME_BYTES - 1) begin
						rsp.frame_done = 1'b1;
						pos            = '0;
						skip_rest      = 1'b0;
						ms_count       = '0;
					end else begin
						pos = pos + 1'b1;
					end
				end
			end
			OP_TICK: begin
				if (ms_count != TICKS_SATURATED)
					ms_count = ms_count + 1'b1;
			end
			OP_READ: begin
				rsp.read_value = servo[req.channel_index];
			end
			default: ;
		endcase
		rsp.link_ok = (ms_count != TICKS_SATURATED) && (ms_count <= link_timeout);
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (fault_count < 30)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got,
				want);
		fault_count++;
	endtask

	always @(posedge clk) begin : monitor
		result_t want;
		result_t fresh;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (due_responses.size() == 0) begin
					report_mismatch("result with none outstanding", rsp_bus, 0);
				end else begin
					want = due_responses.pop_front();
					if (rsp_bus.read_value !== want.read_value)
						report_mismatch("read_value", rsp_bus.read_value, want.read_value);
					if (rsp_bus.link_ok !== want.link_ok)
						report_mismatch("link_ok", rsp_bus.link_ok, want.link_ok);
					if (rsp_bus.frame_done !== want.frame_done)
						report_mismatch("frame_done", rsp_bus.frame_done, want.frame_done);
				end
			end
			if (item_valid && !item_stall) begin
				decode_request(req_bus, fresh);
				due_responses.push_back(fresh);
			end
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	always @(posedge clk) begin
		result_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	initial begin
		wait (arst_n);
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("** dsm_servo_frame_decoder: FAILED **");
		$finish;
	end

	task automatic send_request(input item_t req);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		req_bus    <= req;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sent_count++;
	endtask

	function automatic item_t byte_req(input logic [7:0] b, input logic st);
		item_t req;
		req               = item_t'($urandom);
		req.opcode        = OP_BYTE;
		req.byte_value    = b;
		req.frame_start   = st;
		return req;
	endfunction

	function automatic item_t op_req(input logic [1:0] op, input logic [3:0] idx);
		item_t req;
		req               = item_t'($urandom);
		req.opcode        = op;
		req.channel_index = idx;
		return req;
	endfunction

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (due_responses.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic configure(input logic fmt, input logic [4:0] nch,
			input logic [15:0] tmo);
		drain();
		write_reg(CFG_DATA_FORMAT, {15'd0, fmt});
		write_reg(CFG_NUM_CHANNELS, {11'd0, nch});
		write_reg(CFG_TIMEOUT_MS, tmo);
		cfg_we       <= 1'b0;
		fmt_q        = fmt;
		chan_limit   = nch;
		link_timeout = tmo;
	endtask

	function automatic logic [15:0] servo_word();
		int          top;
		logic [5:0]  chan;
		logic [10:0] val;
		top = (chan_limit < MAX_CHANNELS) ? chan_limit : MAX_CHANNELS;
		if (top > 0 && $urandom_range(99) < 85)
			chan = $urandom_range(top - 1);
		else
			chan = fmt_q ? $urandom_range(63) : $urandom_range(31);
		val = $urandom;
		return fmt_q ? {chan, val[9:0]} : {chan[4:0], val};
	endfunction

	task automatic send_frame(input int len, input logic lead);
		logic [15:0] word;
		logic [7:0]  b;
		logic        st;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 10)
				send_request(op_req($urandom_range(1) ? OP_TICK : OP_READ, $urandom));
			if (i < 2) begin
				b = $urandom;
			end else if (i % 2 == 0) begin
				word = servo_word();
				b    = word[15:8];
			end else begin
				b = word[7:0];
			end
			st = (i == 0) ? lead : ($urandom_range(199) == 0);
			send_request(byte_req(b, st));
		end
		last_whole = (len == FRAME_BYTES);
	endtask

	task automatic run_traffic(input int n);
		int first;
		int pick;
		int len;
		first = sent_count;
		while (sent_count - first < n) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(1, FRAME_BYTES - 1)
					: FRAME_BYTES;
				send_frame(len, !(last_whole && $urandom_range(3) == 0));
			end else if (pick < 80) begin
				len = (link_timeout < 8) ? $urandom_range(1, link_timeout + 3)
					: $urandom_range(1, 6);
				repeat (len) send_request(op_req(OP_TICK, $urandom));
			end else if (pick < 92) begin
				repeat ($urandom_range(1, 4)) send_request(op_req(OP_READ, $urandom));
			end else begin
				repeat ($urandom_range(1, 3)) send_request(item_t'($urandom));
				last_whole = 1'b0;
			end
		end
	endtask

	task automatic test_idle_link();
		configure(FMT_DSMX, 5'd16, 16'hFFFF);
		send_request(op_req(OP_READ, 4'd0));
		send_request(op_req(OP_TICK, 4'd0));
		send_request(op_req(OP_NONE, 4'd15));
		send_request(byte_req(8'hFF, 1'b0));
		send_request(op_req(OP_READ, 4'd15));
	endtask

	task automatic test_dsmx_frame();
		logic [7:0] frame_bytes [FRAME_BYTES] = '{
			8'h00, 8'hA2, 8'h07, 8'hFF, 8'h78, 8'h00, 8'h80, 8'h01,
			8'h08, 8'h55, 8'h10, 8'h22, 8'h18, 8'h33, 8'h20, 8'h44};
		// partial frame, dropped by the next frame start
		send_request(byte_req(8'h5A, 1'b1));
		send_request(byte_req(8'hC3, 1'b0));
		send_request(byte_req(8'h7F, 1'b0));
		foreach (frame_bytes[i])
			send_request(byte_req(frame_bytes[i], i == 0));
		send_request(op_req(OP_READ, 4'd0));
		send_request(op_req(OP_READ, 4'd15));
		send_request(op_req(OP_READ, 4'd1));
	endtask

	task automatic test_dsm2_frames();
		configure(FMT_DSM2, 5'd16, 16'd1000);
		run_traffic(200);
	endtask

	task automatic test_channel_limits();
		configure(FMT_DSMX, 5'd1, 16'd1000);
		run_traffic(150);
		configure(FMT_DSM2, 5'd0, 16'd500);
		run_traffic(100);
		configure(FMT_DSMX, 5'd31, 16'd2000);
		run_traffic(150);
	endtask

	task automatic test_link_timeout();
		configure(FMT_DSMX, 5'd12, 16'd1);
		run_traffic(150);
		configure(FMT_DSM2, 5'd12, 16'd0);
		run_traffic(100);
	endtask

	task automatic test_full_rate();
		steady = 1'b1;
		configure($urandom_range(1), 5'd16, 16'd4);
		run_traffic(250);
		drain();
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		repeat (3) begin
			configure($urandom_range(1), $urandom_range(31),
				$urandom_range(1) ? $urandom_range(12) : $urandom_range(65535));
			run_traffic(90);
		end
	endtask

	initial begin
		reset_predictor();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_link();
		test_dsmx_frame();
		test_dsm2_frames();
		test_channel_limits();
		test_link_timeout();
		test_full_rate();
		test_random_traffic();
		drain();
		repeat (5) @(posedge clk);
		if (fault_count == 0)
			$display("** dsm_servo_frame_decoder: PASSED **");
		else
			$display("** dsm_servo_frame_decoder: FAILED **");
		$finish;
	end

endmodule
